[rtl/rwcg_pkg.sv]
// Package: shared types, codes and sizes of the replay window counter guard.
package rwcg_pkg;

  localparam int WINDOW   = 64;
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int NUM_CTX  = 3;
  localparam int CTR_W    = 64;

  typedef enum logic [2:0] {
    KIND_SEND     = 3'd0,
    KIND_CHECK    = 3'd1,
    KIND_ADMIT    = 3'd2,
    KIND_ACTIVATE = 3'd3,
    KIND_RESTART  = 3'd4,
    KIND_UNKNOWN  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FENCED  = 3'd1,
    ST_STRUCT  = 3'd2,
    ST_COUNTER = 3'd3,
    ST_REPLAY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    LC_NONE    = 2'd0,
    LC_ACTIVE  = 2'd1,
    LC_RESTART = 2'd2,
    LC_COMMIT  = 2'd3
  } lc_e;

  localparam logic [1:0] CTX_DATA = 2'd0;
  localparam logic [1:0] CTX_ACK  = 2'd1;
  localparam logic [1:0] CTX_E2E  = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       lane;
    logic             e2e_sel;
    logic [CTR_W-1:0] counter;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [CTR_W-1:0] counter_out;
    logic [CTR_W-1:0] epoch;
  } result_t;

  typedef struct packed {
    logic              seen;
    logic [CTR_W-1:0]  highest;
    logic [WINDOW-1:0] map;
  } win_upd_t;

endpackage

[rtl/rwcg_if.sv]
// Interfaces: request and response channels of the replay window counter guard.
interface rwcg_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  lane;
  logic        e2e_sel;
  logic [63:0] counter;

  modport source (output valid, kind, lane, e2e_sel, counter, input ready);
  modport sink   (input valid, kind, lane, e2e_sel, counter, output ready);
endinterface

interface rwcg_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] counter_out;
  logic [63:0] epoch;

  modport source (output valid, status, counter_out, epoch, input ready);
  modport sink   (input valid, status, counter_out, epoch, output ready);
endinterface

[rtl/rwcg_window.sv]
// Sliding bitmap window: replay test and the window state after an admit.
module rwcg_window import rwcg_pkg::*; (
  input  logic [CTR_W-1:0]  highest_i,
  input  logic [WINDOW-1:0] map_i,
  input  logic [CTR_W-1:0]  counter_i,
  output win_upd_t          upd_o
);

  logic             above;
  logic [CTR_W-1:0] d_below;
  logic [CTR_W-1:0] d_above;
  logic             in_win;
  logic             far_above;

  assign above     = counter_i > highest_i;
  assign d_below   = highest_i - counter_i;
  assign d_above   = counter_i - highest_i;
  assign in_win    = d_below < CTR_W'(WINDOW);
  assign far_above = d_above >= CTR_W'(WINDOW);

  always_comb begin
    upd_o.seen    = !above && in_win && ((map_i >> d_below[IDX_W-1:0]) & WINDOW'(1)) != '0;
    upd_o.highest = highest_i;
    upd_o.map     = map_i;
    if (above) begin
      upd_o.highest = counter_i;
      if (far_above) begin
        upd_o.map = WINDOW'(1);
      end else begin
        upd_o.map = (map_i << d_above[IDX_W-1:0]) | WINDOW'(1);
      end
    end else if (in_win) begin
      upd_o.map = map_i | (WINDOW'(1) << d_below[IDX_W-1:0]);
    end
  end

endmodule

[rtl/rwcg_core.sv]
// Context state and the step logic that acts on one item per enable.
module rwcg_core import rwcg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  output result_t res_o
);

  lc_e               lc_q, lc_d;
  logic [CTR_W-1:0]  epoch_q, epoch_d;
  logic [CTR_W-1:0]  send_q [NUM_CTX];
  logic [CTR_W-1:0]  send_d [NUM_CTX];
  logic [CTR_W-1:0]  high_q [NUM_CTX];
  logic [CTR_W-1:0]  high_d [NUM_CTX];
  logic [WINDOW-1:0] map_q  [NUM_CTX];
  logic [WINDOW-1:0] map_d  [NUM_CTX];

  logic             ctx_bad;
  logic [1:0]       ctx;
  logic [CTR_W-1:0] sn;
  logic [CTR_W-1:0] epoch_inc;
  win_upd_t         upd;

  always_comb begin
    ctx_bad = 1'b0;
    if (item_i.e2e_sel) begin
      ctx = CTX_E2E;
    end else if (item_i.lane == CTX_DATA || item_i.lane == CTX_ACK) begin
      ctx = item_i.lane;
    end else begin
      ctx     = CTX_DATA;
      ctx_bad = 1'b1;
    end
  end

  assign sn        = send_q[ctx];
  assign epoch_inc = epoch_q + CTR_W'(1);

  rwcg_window u_window (
    .highest_i (high_q[ctx]),
    .map_i     (map_q[ctx]),
    .counter_i (item_i.counter),
    .upd_o     (upd)
  );

  always_comb begin
    lc_d              = lc_q;
    epoch_d           = epoch_q;
    send_d            = send_q;
    high_d            = high_q;
    map_d             = map_q;
    res_o.status      = ST_OK;
    res_o.counter_out = '0;
    case (item_i.kind)
      KIND_SEND, KIND_CHECK, KIND_ADMIT: begin
        if (lc_q != LC_ACTIVE) begin
          res_o.status = ST_FENCED;
        end else if (item_i.kind == KIND_SEND) begin
          if (ctx_bad) begin
            res_o.status = ST_STRUCT;
          end else if (sn == '0 || sn == '1) begin
            res_o.status = ST_COUNTER;
          end else begin
            res_o.counter_out = sn;
            send_d[ctx]       = sn + CTR_W'(1);
          end
        end else if (item_i.counter == '0) begin
          res_o.status = ST_COUNTER;
        end else if (ctx_bad) begin
          res_o.status = ST_STRUCT;
        end else if (upd.seen) begin
          res_o.status = ST_REPLAY;
        end else if (item_i.kind == KIND_ADMIT) begin
          high_d[ctx] = upd.highest;
          map_d[ctx]  = upd.map;
        end
      end
      KIND_ACTIVATE: begin
        if (lc_q == LC_NONE || lc_q == LC_RESTART) begin
          // epoch zero means never installed, so the wrap skips it
          epoch_d = (epoch_inc == '0) ? CTR_W'(1) : epoch_inc;
          for (int i = 0; i < NUM_CTX; i++) begin
            send_d[i] = CTR_W'(1);
            high_d[i] = '0;
            map_d[i]  = '0;
          end
          lc_d = LC_ACTIVE;
        end else begin
          res_o.status = ST_FENCED;
        end
      end
      KIND_RESTART, KIND_UNKNOWN: begin
        for (int i = 0; i < NUM_CTX; i++) begin
          send_d[i] = '0;
          high_d[i] = '0;
          map_d[i]  = '0;
        end
        lc_d = (item_i.kind == KIND_RESTART) ? LC_RESTART : LC_COMMIT;
      end
      default: res_o.status = ST_STRUCT;
    endcase
    res_o.epoch = epoch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q    <= LC_NONE;
      epoch_q <= '0;
      for (int i = 0; i < NUM_CTX; i++) begin
        send_q[i] <= '0;
        high_q[i] <= '0;
        map_q[i]  <= '0;
      end
    end else if (en_i) begin
      lc_q    <= lc_d;
      epoch_q <= epoch_d;
      send_q  <= send_d;
      high_q  <= high_d;
      map_q   <= map_d;
    end
  end

endmodule

[rtl/replay_window_counter_guard.sv]
// Top level: request register, guard core and response register.
//
// Anti-replay guard for three packet contexts (hop data, hop ack, end-to-end).
// req_i takes one item per cycle (kind, lane, e2e_sel, counter) while no
// stall holds it; rsp_o gives exactly one result per item (status,
// counter_out, epoch), in order. An item is accepted when valid and ready
// are both high. An accepted item waits in the request register and is
// processed as it moves into the response register; its result is shown on
// rsp_o from then until taken. Throughput: one item per cycle while the
// receiver keeps up; the context state is read, checked and written back as
// an item moves from the request register to the response register, so
// each item sees all earlier items' updates.
// When the receiver stalls, the result holds in the response register and
// one more item waits in the request register; req_i.ready then drops.
// Reset (rst_ni low, asynchronous) empties both registers, leaves the block
// not installed, with epoch zero and all contexts cleared.
module replay_window_counter_guard import rwcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rwcg_req_if.sink   req_i,
  rwcg_rsp_if.source rsp_o
);

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t core_res;
  logic    advance;

  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_item_q.kind    <= req_i.kind;
      s1_item_q.lane    <= req_i.lane;
      s1_item_q.e2e_sel <= req_i.e2e_sel;
      s1_item_q.counter <= req_i.counter;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  rwcg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (s1_item_q),
    .res_o  (core_res)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_res_q.status;
  assign rsp_o.counter_out = out_res_q.counter_out;
  assign rsp_o.epoch       = out_res_q.epoch;

  a_taken_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.counter_out != '0 |-> out_res_q.status == ST_OK)
    else $error("counter handed out with a non-ok status");

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("pending request item dropped");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no response");

endmodule
